// File: sv/u8sd_pkg.sv
package u8sd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned CNT_W  = 2;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(24'hFFFD);

   // Lead and continuation byte masks / patterns
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

   localparam logic [BYTE_W-1:0] PAYLOAD6 = 8'h3F;
   localparam logic [BYTE_W-1:0] PAYLOAD5 = 8'h1F;
   localparam logic [BYTE_W-1:0] PAYLOAD4 = 8'h0F;
   localparam logic [BYTE_W-1:0] PAYLOAD3 = 8'h07;

   // Results caused by one input word: rep_cnt replacements, then an optional tail
   typedef struct packed {
      logic [CNT_W-1:0] rep_cnt;
      logic             tail_valid;
      logic [CP_W-1:0]  tail_cp;
      logic             tail_rep;
   } burst_type;

endpackage

// File: sv/utf8_stream_decoder.sv
// Channel | Ports                                              | Direction
// req     | req_valid, req_ready, req_data_byte                | in
// rsp     | rsp_valid, rsp_ready, rsp_code_point, rsp_replaced, rsp_last | out
//
// Decode is combinational: a byte's result burst enters the output register the
// cycle after the word is accepted, or waits in the second entry while a burst drains.
// One result leaves per cycle while rsp_ready is high, so a byte causing several results
// holds the output until all have left; req_ready is low while the second entry is full.
// Sustained rate is one byte per cycle when each byte causes at most one result and
// rsp_ready stays high. Reset (synchronous) clears the decode state, empties both entries.
module utf8_stream_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [u8sd_pkg::BYTE_W-1:0] req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [u8sd_pkg::CP_W-1:0]   rsp_code_point,
   output logic                        rsp_replaced,
   output logic                        rsp_last
);
   import u8sd_pkg::*;

   logic [CP_W-1:0]  partial_ff, partial_in;
   logic [CNT_W-1:0] expect_ff, expect_in;
   logic [CNT_W-1:0] held_ff, held_in;

   burst_type a_ff, a_in, b_ff, b_in, new_burst;
   logic      a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   logic      new_valid, accept, b_free, is_cont;
   logic [CNT_W-1:0] exp_dec;

   assign req_ready = !a_valid_ff;
   assign accept    = req_valid && req_ready;

   // decode
   always_comb begin
      partial_in = partial_ff;
      expect_in  = expect_ff;
      held_in    = held_ff;
      new_burst  = '{rep_cnt: '0, tail_valid: 1'b0, tail_cp: '0, tail_rep: 1'b0};
      is_cont    = (req_data_byte & CONT_MASK) == CONT_PAT;
      exp_dec    = expect_ff - CNT_W'(1);
      if (expect_ff != '0 && is_cont) begin
         partial_in = {partial_ff[CP_W-7:0], req_data_byte[5:0]};
         expect_in  = exp_dec;
         if (exp_dec == '0) begin
            held_in              = '0;
            new_burst.tail_valid = 1'b1;
            new_burst.tail_cp    = partial_in;
         end else begin
            held_in = held_ff + CNT_W'(1);
         end
      end else begin
         if (expect_ff != '0) begin
            // broken sequence: one replacement per held word
            new_burst.rep_cnt = held_ff;
            partial_in        = '0;
            expect_in         = '0;
            held_in           = '0;
         end
         if (req_data_byte == '0) begin
            // end of text, no tail result
         end else if (!req_data_byte[BYTE_W-1]) begin
            new_burst.tail_valid = 1'b1;
            new_burst.tail_cp    = CP_W'(req_data_byte);
         end else if ((req_data_byte & LEAD2_MASK) == LEAD2_PAT) begin
            partial_in = CP_W'(req_data_byte & PAYLOAD5);
            expect_in  = CNT_W'(1);
            held_in    = CNT_W'(1);
         end else if ((req_data_byte & LEAD3_MASK) == LEAD3_PAT) begin
            partial_in = CP_W'(req_data_byte & PAYLOAD4);
            expect_in  = CNT_W'(2);
            held_in    = CNT_W'(1);
         end else if ((req_data_byte & LEAD4_MASK) == LEAD4_PAT) begin
            partial_in = CP_W'(req_data_byte & PAYLOAD3);
            expect_in  = CNT_W'(3);
            held_in    = CNT_W'(1);
         end else begin
            new_burst.tail_valid = 1'b1;
            new_burst.tail_cp    = REPLACEMENT_CP;
            new_burst.tail_rep   = 1'b1;
         end
      end
      new_valid = accept && (new_burst.rep_cnt != '0 || new_burst.tail_valid);
   end

   // output side: replacements first, then the tail
   assign rsp_valid      = b_valid_ff;
   assign rsp_code_point = (b_ff.rep_cnt != '0) ? REPLACEMENT_CP : b_ff.tail_cp;
   assign rsp_replaced   = (b_ff.rep_cnt != '0) ? 1'b1 : b_ff.tail_rep;
   assign rsp_last       = (b_ff.rep_cnt == '0) ||
                           (b_ff.rep_cnt == CNT_W'(1) && !b_ff.tail_valid);

   assign b_free = !b_valid_ff || (rsp_ready && rsp_last);

   always_comb begin
      a_in       = a_ff;
      a_valid_in = a_valid_ff;
      b_in       = b_ff;
      b_valid_in = b_valid_ff;
      if (b_valid_ff && rsp_ready && !rsp_last) begin
         b_in.rep_cnt = b_ff.rep_cnt - CNT_W'(1);
      end
      if (b_free) begin
         if (a_valid_ff) begin
            b_in       = a_ff;
            b_valid_in = 1'b1;
            a_valid_in = 1'b0;
         end else if (new_valid) begin
            b_in       = new_burst;
            b_valid_in = 1'b1;
         end else begin
            b_valid_in = 1'b0;
         end
      end else if (new_valid) begin
         a_in       = new_burst;
         a_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         expect_ff  <= '0;
         held_ff    <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            partial_ff <= partial_in;
            expect_ff  <= expect_in;
            held_ff    <= held_in;
         end
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

// File: test/tb_utf8_stream_decoder.sv
module tb_utf8_stream_decoder;
   import u8sd_pkg::*;

   localparam int LIMIT_CYCLES = 200000;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            replaced;
      logic            is_last;
   } cp_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CP_W-1:0]   rsp_code_point;
   logic              rsp_replaced;
   logic              rsp_last;

   // decoder state mirrored by the predictor
   logic [CP_W-1:0]  dec_cp = '0;
   logic [CNT_W-1:0] dec_need = '0;
   logic [CNT_W-1:0] dec_held = '0;

   cp_result_type expected_cp_q[$];
   bit         idle_on = 1'b1;
   int         err_cnt = 0;
   int         cycle_cnt = 0;
   int         stall_left = 0;
   int         bytes_sent = 0;

   utf8_stream_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_replaced   (rsp_replaced),
      .rsp_last       (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > LIMIT_CYCLES) begin
         $display("tb_utf8_stream_decoder failed");
         $finish;
      end
   end

   // Works out the code points one accepted byte produces.
   function automatic void predict_decode(input logic [BYTE_W-1:0] b);
      cp_result_type res[4];
      int         n;
      bit         taken;
      n = 0;
      taken = 1'b0;
      if (dec_need != 0) begin
         if ((b & CONT_MASK) == CONT_PAT) begin
            taken = 1'b1;
            dec_cp = {dec_cp[CP_W-7:0], b[5:0]};
            dec_held = dec_held + 1'b1;
            dec_need = dec_need - 1'b1;
            if (dec_need == 0) begin
               dec_held = '0;
               res[n] = '{code_point: dec_cp, replaced: 1'b0, is_last: 1'b0};
               n++;
            end
         end else begin
            // broken sequence: one replacement per held byte, then b is decoded afresh
            for (int i = 0; i < dec_held && i < 3; i++) begin
               res[n] = '{code_point: REPLACEMENT_CP, replaced: 1'b1, is_last: 1'b0};
               n++;
            end
            dec_held = '0;
            dec_need = '0;
            dec_cp = '0;
         end
      end
      if (!taken) begin
         if (b == 8'h00) begin
            // end of text, no result of its own
         end else if (b < 8'h80) begin
            res[n] = '{code_point: CP_W'(b), replaced: 1'b0, is_last: 1'b0};
            n++;
         end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            dec_cp = CP_W'(b & PAYLOAD5);
            dec_need = 2'd1;
            dec_held = 2'd1;
         end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            dec_cp = CP_W'(b & PAYLOAD4);
            dec_need = 2'd2;
            dec_held = 2'd1;
         end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            dec_cp = CP_W'(b & PAYLOAD3);
            dec_need = 2'd3;
            dec_held = 2'd1;
         end else begin
            res[n] = '{code_point: REPLACEMENT_CP, replaced: 1'b1, is_last: 1'b0};
            n++;
         end
      end
      if (n > 0)
         res[n-1].is_last = 1'b1;
      for (int i = 0; i < n; i++)
         expected_cp_q.push_back(res[i]);
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_decode(b);
      if (b != 8'h00)
         bytes_sent++;
   endtask

   task automatic send_seq(input logic [BYTE_W-1:0] s[]);
      foreach (s[i])
         send_byte(s[i]);
   endtask

   function automatic logic [BYTE_W-1:0] rand_lead(input int len);
      case (len)
         2: rand_lead = 8'hC0 | 8'($urandom_range(0, 31));
         3: rand_lead = 8'hE0 | 8'($urandom_range(0, 15));
         default: rand_lead = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] rand_cont();
      rand_cont = 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic test_ascii();
      send_seq('{8'h01, 8'h7F, 8'h00});
   endtask

   task automatic test_multibyte();
      send_seq('{8'hC2, 8'hA9});
      send_seq('{8'hE2, 8'h82, 8'hAC});
      // largest code point the masks allow
      send_seq('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
   endtask

   task automatic test_malformed();
      send_seq('{8'h80, 8'hBF, 8'hF8, 8'hFF});
   endtask

   task automatic test_broken_seq();
      send_seq('{8'hF0, 8'h90, 8'h80, 8'h41});
      send_seq('{8'hC2, 8'hF8});
   endtask

   task automatic test_end_of_text();
      send_seq('{8'hE0, 8'h80, 8'h00});
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_cp_q.size() != 0);
   endtask

   task automatic test_random_text(input int count);
      int kind;
      int len;
      int k;
      int b;
      k = bytes_sent + count;
      while (bytes_sent < k) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            send_byte(8'($urandom_range(1, 127)));
         end else if (kind < 70) begin
            len = $urandom_range(2, 4);
            send_byte(rand_lead(len));
            repeat (len - 1) send_byte(rand_cont());
         end else if (kind < 82) begin
            // truncated sequence followed by a non-continuation byte
            len = $urandom_range(2, 4);
            send_byte(rand_lead(len));
            repeat ($urandom_range(0, len - 2)) send_byte(rand_cont());
            b = $urandom_range(0, 191);
            if (b >= 128)
               b += 64;
            send_byte(8'(b));
         end else if (kind < 95) begin
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 1) == 1) begin
               len = $urandom_range(2, 4);
               send_byte(rand_lead(len));
               repeat ($urandom_range(0, len - 2)) send_byte(rand_cont());
            end
            send_byte(8'h00);
         end
      end
   endtask

   always @(posedge clock) begin : rsp_side
      cp_result_type want;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end

      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_cp_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual code_point %h",
                     $time, rsp_code_point);
            err_cnt++;
         end else begin
            want = expected_cp_q.pop_front();
            if (rsp_code_point !== want.code_point) begin
               $display("%0t: code_point expected %h actual %h",
                        $time, want.code_point, rsp_code_point);
               err_cnt++;
            end
            if (rsp_replaced !== want.replaced) begin
               $display("%0t: replaced expected %b actual %b",
                        $time, want.replaced, rsp_replaced);
               err_cnt++;
            end
            if (rsp_last !== want.is_last) begin
               $display("%0t: last expected %b actual %b",
                        $time, want.is_last, rsp_last);
               err_cnt++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ascii();
      test_multibyte();
      test_malformed();
      test_broken_seq();
      test_end_of_text();
      wait_drain();

      test_random_text(125);
      wait_drain();
      test_random_text(100);

      // tail of the run at full rate on both sides
      idle_on = 1'b0;
      test_random_text(75);

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_cp_q.size() != 0);
      repeat (16) @(posedge clock);
      if (err_cnt == 0)
         $display("tb_utf8_stream_decoder passed");
      else
         $display("tb_utf8_stream_decoder failed");
      $finish;
   end

endmodule
